/* src/box_feet_to_ground_plane_macros.svh */
// Assertion macros for the RTL.
`ifndef BOX_FEET_TO_GROUND_PLANE_MACROS_SVH
`define BOX_FEET_TO_GROUND_PLANE_MACROS_SVH
`ifndef SYNTH
`define BFG_ASSERT_IMPL(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define BFG_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define BFG_ASSERT_IMPL(label, clk, rst, a, b)
`define BFG_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

/* src/bfg_pkg.sv */
package bfg_pkg;
   localparam int PIXEL_BITS = 12;
   localparam int PT_BITS = PIXEL_BITS + 1;
   localparam int PROD_BITS = 32 + PT_BITS + 1;
   localparam int ACC_BITS = PROD_BITS + 2;
   localparam int Q_FRAC = 16;
   localparam int DIV_STEPS = 32;
   localparam int NUM_REGS = 8;
   localparam int IDX_BITS = $clog2(NUM_REGS);
   localparam int LAT = DIV_STEPS + 6;

   localparam logic [IDX_BITS-1:0] REG_COEF0 = 3'd0;
   localparam logic [IDX_BITS-1:0] REG_COEF1 = 3'd1;
   localparam logic [IDX_BITS-1:0] REG_COEF2 = 3'd2;
   localparam logic [IDX_BITS-1:0] REG_COEF3 = 3'd3;
   localparam logic [IDX_BITS-1:0] REG_COEF4 = 3'd4;
   localparam logic [IDX_BITS-1:0] REG_CAMERA = 3'd5;
   localparam logic [IDX_BITS-1:0] REG_RMIN = 3'd6;
   localparam logic [IDX_BITS-1:0] REG_RMAX = 3'd7;

   localparam logic [63:0] RESET_VALS [NUM_REGS] = '{
      64'd16777216, 64'd0, 64'd16777216, 64'd0, 64'd16777216,
      64'd0, 64'd140737488388096, 64'd1125899907432448};

   typedef logic [63:0] reg_file_type [NUM_REGS];
endpackage

/* src/bfg_req_if.sv */
interface bfg_req_if;
   logic valid;
   logic ready;
   logic [bfg_pkg::PIXEL_BITS-1:0] box_left;
   logic [bfg_pkg::PIXEL_BITS-1:0] box_top;
   logic [bfg_pkg::PIXEL_BITS-1:0] box_width;
   logic [bfg_pkg::PIXEL_BITS-1:0] box_height;
   modport source (output valid, box_left, box_top, box_width, box_height, input ready);
   modport sink (input valid, box_left, box_top, box_width, box_height, output ready);
endinterface

/* src/bfg_rsp_if.sv */
interface bfg_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] ground_x;
   logic signed [31:0] ground_y;
   logic signed [31:0] offset_x;
   logic signed [31:0] offset_y;
   logic in_region;
   logic degenerate;
   modport source (output valid, ground_x, ground_y, offset_x, offset_y, in_region,
                   degenerate, input ready);
   modport sink (input valid, ground_x, ground_y, offset_x, offset_y, in_region,
                 degenerate, output ready);
endinterface

/* src/box_feet_to_ground_plane.sv */
// Projects the feet point of a detection box onto the ground plane.
// The req channel carries one box per item (left, top, width, height in
// pixels); the rsp channel returns the ground point, its offset from the
// camera, an in-region flag and a degenerate flag for a zero denominator.
// Items are accepted on valid and ready both high, one per cycle.
// The pipeline has 38 register stages: feet point, products, sums,
// magnitudes, 32 restoring divider stages for X and Y in parallel,
// saturation, and offset and region checks. Throughput is one item per
// cycle as long as the receiver does not stall the final rsp item.
// The whole pipeline advances together, so while the final rsp item is
// held by a stalled receiver, req ready is low and nothing moves; items
// in flight are kept intact. Synchronous reset empties the pipeline and
// loads the register defaults: identity homography, camera at the origin
// and a region from (0.5, 0.5) to (9.0, 4.0).
// Configuration is written through csr_we, csr_index and csr_wdata while
// the block is idle; the user must keep this, unchecked by the block.
`include "box_feet_to_ground_plane_macros.svh"
module box_feet_to_ground_plane (
   input  logic clock,
   input  logic reset,
   bfg_req_if.sink req,
   bfg_rsp_if.source rsp,
   input  logic csr_we,
   input  logic [bfg_pkg::IDX_BITS-1:0] csr_index,
   input  logic [63:0] csr_wdata
);
   localparam int A = bfg_pkg::ACC_BITS;
   localparam int N = bfg_pkg::DIV_STEPS;

   bfg_pkg::reg_file_type regs_ff;
   logic [bfg_pkg::LAT-1:0] vld_ff;
   logic adv;

   logic [bfg_pkg::PT_BITS-1:0] px_ff, py_ff;
   logic signed [bfg_pkg::PROD_BITS-1:0] prod_ff [6];
   logic signed [A-1:0] nx_ff, ny_ff, d_ff;
   logic [A-1:0] dm_ff [N+1];
   logic [A-1:0] rx_ff [N+1], ry_ff [N+1];
   logic [31:0] wx_ff [N+1], wy_ff [N+1];
   logic [N:0] negx_ff, negy_ff, ovx_ff, ovy_ff, dgn_ff;
   logic signed [31:0] gx_ff, gy_ff;
   logic dg_ff;
   logic signed [31:0] ogx_ff, ogy_ff, ox_ff, oy_ff;
   logic oin_ff, odg_ff;

   logic [A-1:0] nxm_in, nym_in, dm_in;
   logic [A-1:0] rx_in [N], ry_in [N];
   logic [A:0] tx, ty;
   logic signed [31:0] gx_in, gy_in;
   logic signed [32:0] dx, dy;

   assign adv = !vld_ff[bfg_pkg::LAT-1] || rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= bfg_pkg::RESET_VALS;
      end else if (csr_we) begin
         regs_ff[csr_index] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[bfg_pkg::LAT-2:0], req.valid};
      end
   end

   function automatic logic [A-1:0] mag(input logic signed [A-1:0] v);
      return v[A-1] ? A'(-v) : A'(v);
   endfunction

   function automatic logic signed [31:0] fin(input logic [31:0] w, input logic neg,
                                              input logic ov);
      if (neg) begin
         return (ov || w[31]) ? 32'sh8000_0000 : -$signed(w);
      end
      return (ov || w[31]) ? 32'sh7FFF_FFFF : $signed(w);
   endfunction

   function automatic logic signed [31:0] sat(input logic signed [32:0] v);
      if (v[32] != v[31]) begin
         return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return v[31:0];
   endfunction

   always_comb begin
      nxm_in = mag(nx_ff);
      nym_in = mag(ny_ff);
      dm_in = mag(d_ff);
      for (int i = 0; i < N; i++) begin
         tx = {rx_ff[i], wx_ff[i][31]};
         ty = {ry_ff[i], wy_ff[i][31]};
         rx_in[i] = (tx >= {1'b0, dm_ff[i]}) ? A'(tx - {1'b0, dm_ff[i]}) : tx[A-1:0];
         ry_in[i] = (ty >= {1'b0, dm_ff[i]}) ? A'(ty - {1'b0, dm_ff[i]}) : ty[A-1:0];
      end
      gx_in = dgn_ff[N] ? 32'sd0 : fin(wx_ff[N], negx_ff[N], ovx_ff[N]);
      gy_in = dgn_ff[N] ? 32'sd0 : fin(wy_ff[N], negy_ff[N], ovy_ff[N]);
      dx = 33'(gx_ff) - 33'($signed(regs_ff[bfg_pkg::REG_CAMERA][31:0]));
      dy = 33'(gy_ff) - 33'($signed(regs_ff[bfg_pkg::REG_CAMERA][63:32]));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff <= bfg_pkg::PT_BITS'(req.box_left) + bfg_pkg::PT_BITS'(req.box_width >> 1);
         py_ff <= bfg_pkg::PT_BITS'(req.box_top) + bfg_pkg::PT_BITS'(req.box_height);
         prod_ff[0] <= $signed(regs_ff[bfg_pkg::REG_COEF0][31:0]) * $signed({1'b0, px_ff});
         prod_ff[1] <= $signed(regs_ff[bfg_pkg::REG_COEF0][63:32]) * $signed({1'b0, py_ff});
         prod_ff[2] <= $signed(regs_ff[bfg_pkg::REG_COEF1][63:32]) * $signed({1'b0, px_ff});
         prod_ff[3] <= $signed(regs_ff[bfg_pkg::REG_COEF2][31:0]) * $signed({1'b0, py_ff});
         prod_ff[4] <= $signed(regs_ff[bfg_pkg::REG_COEF3][31:0]) * $signed({1'b0, px_ff});
         prod_ff[5] <= $signed(regs_ff[bfg_pkg::REG_COEF3][63:32]) * $signed({1'b0, py_ff});
         nx_ff <= A'(prod_ff[0]) + A'(prod_ff[1])
                  + A'($signed(regs_ff[bfg_pkg::REG_COEF1][31:0]));
         ny_ff <= A'(prod_ff[2]) + A'(prod_ff[3])
                  + A'($signed(regs_ff[bfg_pkg::REG_COEF2][63:32]));
         d_ff <= A'(prod_ff[4]) + A'(prod_ff[5])
                 + A'($signed(regs_ff[bfg_pkg::REG_COEF4][31:0]));
         dm_ff[0] <= dm_in;
         rx_ff[0] <= nxm_in >> bfg_pkg::Q_FRAC;
         ry_ff[0] <= nym_in >> bfg_pkg::Q_FRAC;
         wx_ff[0] <= {nxm_in[bfg_pkg::Q_FRAC-1:0], 16'd0};
         wy_ff[0] <= {nym_in[bfg_pkg::Q_FRAC-1:0], 16'd0};
         negx_ff[0] <= nx_ff[A-1] ^ d_ff[A-1];
         negy_ff[0] <= ny_ff[A-1] ^ d_ff[A-1];
         ovx_ff[0] <= (A+16)'(nxm_in) >= (A+16)'({dm_in, 16'd0});
         ovy_ff[0] <= (A+16)'(nym_in) >= (A+16)'({dm_in, 16'd0});
         dgn_ff[0] <= (d_ff == '0);
         for (int i = 0; i < N; i++) begin
            dm_ff[i+1] <= dm_ff[i];
            rx_ff[i+1] <= rx_in[i];
            ry_ff[i+1] <= ry_in[i];
            wx_ff[i+1] <= {wx_ff[i][30:0],
                           ({rx_ff[i], wx_ff[i][31]} >= {1'b0, dm_ff[i]})};
            wy_ff[i+1] <= {wy_ff[i][30:0],
                           ({ry_ff[i], wy_ff[i][31]} >= {1'b0, dm_ff[i]})};
            negx_ff[i+1] <= negx_ff[i];
            negy_ff[i+1] <= negy_ff[i];
            ovx_ff[i+1] <= ovx_ff[i];
            ovy_ff[i+1] <= ovy_ff[i];
            dgn_ff[i+1] <= dgn_ff[i];
         end
         gx_ff <= gx_in;
         gy_ff <= gy_in;
         dg_ff <= dgn_ff[N];
         ogx_ff <= gx_ff;
         ogy_ff <= gy_ff;
         ox_ff <= sat(dx);
         oy_ff <= sat(dy);
         odg_ff <= dg_ff;
         oin_ff <= gx_ff >= $signed(regs_ff[bfg_pkg::REG_RMIN][31:0])
                && gy_ff >= $signed(regs_ff[bfg_pkg::REG_RMIN][63:32])
                && gx_ff <= $signed(regs_ff[bfg_pkg::REG_RMAX][31:0])
                && gy_ff <= $signed(regs_ff[bfg_pkg::REG_RMAX][63:32]);
      end
   end

   assign rsp.valid = vld_ff[bfg_pkg::LAT-1];
   assign rsp.ground_x = ogx_ff;
   assign rsp.ground_y = ogy_ff;
   assign rsp.offset_x = ox_ff;
   assign rsp.offset_y = oy_ff;
   assign rsp.in_region = oin_ff;
   assign rsp.degenerate = odg_ff;

   `BFG_ASSERT_IMPL(a_degen_origin, clock, reset, rsp.valid && rsp.degenerate,
                    rsp.ground_x == 32'sd0 && rsp.ground_y == 32'sd0)
   `BFG_ASSERT_IMPL(a_ready_rule, clock, reset, 1'b1, req.ready == (!rsp.valid || rsp.ready))
   `BFG_ASSERT_NEXT(a_hold_stall, clock, reset, rsp.valid && !rsp.ready,
                    rsp.valid && $stable(rsp.ground_x) && $stable(vld_ff))
endmodule

/* test/tb_box_feet_to_ground_plane.sv */
`timescale 1ns / 1ps
module tb_box_feet_to_ground_plane;
   typedef struct packed {
      logic [bfg_pkg::PIXEL_BITS-1:0] left;
      logic [bfg_pkg::PIXEL_BITS-1:0] top;
      logic [bfg_pkg::PIXEL_BITS-1:0] width;
      logic [bfg_pkg::PIXEL_BITS-1:0] height;
   } box_type;

   typedef struct packed {
      logic signed [31:0] gx;
      logic signed [31:0] gy;
      logic signed [31:0] ox;
      logic signed [31:0] oy;
      logic in_reg;
      logic degen;
   } ground_type;

   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [bfg_pkg::IDX_BITS-1:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   bfg_req_if req ();
   bfg_rsp_if rsp ();

   box_feet_to_ground_plane u_dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   logic [63:0] shadow_regs [bfg_pkg::NUM_REGS];
   box_type pending_boxes [$];
   ground_type expected_points [$];
   int mismatches = 0;
   int received = 0;
   int degen_seen = 0;
   int in_reg_seen = 0;
   int cycle_count = 0;
   bit sender_paused = 1'b0;
   bit long_hold = 1'b0;
   int burst_left = 0;
   int gap_left = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic longint s32(logic [31:0] v);
      return longint'(signed'(v));
   endfunction

   function automatic longint clamp32(longint v);
      if (v > S32_MAX) return S32_MAX;
      if (v < S32_MIN) return S32_MIN;
      return v;
   endfunction

   function automatic longint divide_q16(longint num, longint den);
      logic [63:0] n, d, q, r, frac, mag;
      bit neg;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      q = n / d;
      r = n % d;
      frac = 0;
      for (int i = 0; i < 16; i++) begin
         r = r << 1;
         frac = frac << 1;
         if (r >= d) begin
            r = r - d;
            frac[0] = 1'b1;
         end
      end
      if (q >= 64'd65536) q = 64'd65536;
      mag = (q << 16) | frac;
      if (neg) begin
         if (mag >= 64'h8000_0000) return S32_MIN;
         return -longint'(mag);
      end
      if (mag > 64'h7FFF_FFFF) return S32_MAX;
      return longint'(mag);
   endfunction

   function automatic ground_type project_feet(box_type b);
      ground_type g;
      longint px, py, nx, ny, d, gx, gy;
      px = longint'(b.left) + longint'(b.width / 2);
      py = longint'(b.top) + longint'(b.height);
      nx = s32(shadow_regs[bfg_pkg::REG_COEF0][31:0]) * px
         + s32(shadow_regs[bfg_pkg::REG_COEF0][63:32]) * py
         + s32(shadow_regs[bfg_pkg::REG_COEF1][31:0]);
      ny = s32(shadow_regs[bfg_pkg::REG_COEF1][63:32]) * px
         + s32(shadow_regs[bfg_pkg::REG_COEF2][31:0]) * py
         + s32(shadow_regs[bfg_pkg::REG_COEF2][63:32]);
      d = s32(shadow_regs[bfg_pkg::REG_COEF3][31:0]) * px
         + s32(shadow_regs[bfg_pkg::REG_COEF3][63:32]) * py
         + s32(shadow_regs[bfg_pkg::REG_COEF4][31:0]);
      gx = 0;
      gy = 0;
      if (d != 0) begin
         gx = divide_q16(nx, d);
         gy = divide_q16(ny, d);
      end
      g.gx = gx[31:0];
      g.gy = gy[31:0];
      g.ox = 32'(clamp32(gx - s32(shadow_regs[bfg_pkg::REG_CAMERA][31:0])));
      g.oy = 32'(clamp32(gy - s32(shadow_regs[bfg_pkg::REG_CAMERA][63:32])));
      g.in_reg = gx >= s32(shadow_regs[bfg_pkg::REG_RMIN][31:0])
         && gy >= s32(shadow_regs[bfg_pkg::REG_RMIN][63:32])
         && gx <= s32(shadow_regs[bfg_pkg::REG_RMAX][31:0])
         && gy <= s32(shadow_regs[bfg_pkg::REG_RMAX][63:32]);
      g.degen = (d == 0);
      return g;
   endfunction

   task automatic write_reg(logic [bfg_pkg::IDX_BITS-1:0] idx, logic [63:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      shadow_regs[idx] = value;
   endtask

   task automatic drain_pipeline();
      wait (pending_boxes.size() == 0 && expected_points.size() == 0);
      repeat (bfg_pkg::LAT + 4) @(posedge clock);
   endtask

   task automatic add_box(box_type b);
      pending_boxes = {pending_boxes, b};
   endtask

   function automatic box_type random_box(int mode);
      box_type b;
      b = box_type'(48'({$urandom, $urandom}));
      if (mode == 0) begin
         b.left = bfg_pkg::PIXEL_BITS'($urandom_range(0, 1000));
         b.top = bfg_pkg::PIXEL_BITS'($urandom_range(0, 1000));
         b.width = bfg_pkg::PIXEL_BITS'($urandom_range(0, 300));
         b.height = bfg_pkg::PIXEL_BITS'($urandom_range(0, 300));
      end
      return b;
   endfunction

   function automatic logic [63:0] q24_pair(int lo, int hi);
      return {32'(hi), 32'(lo)};
   endfunction

   // Driver: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      logic accepted;
      int gap_new;
      accepted = req.valid && req.ready;
      gap_new = gap_left;
      if (reset) begin
         req.valid <= 1'b0;
         req.box_left <= '0;
         req.box_top <= '0;
         req.box_width <= '0;
         req.box_height <= '0;
      end else begin
         if (accepted) begin
            expected_points = {expected_points, project_feet(pending_boxes.pop_front())};
            if (burst_left > 0) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(0, 40);
               gap_new = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
            end
         end
         if (req.valid && !accepted) begin
            req.valid <= 1'b1;
         end else if (gap_new > 0) begin
            gap_left <= gap_new - 1;
            req.valid <= 1'b0;
         end else if (pending_boxes.size() > 0 && !sender_paused) begin
            req.valid <= 1'b1;
            {req.box_left, req.box_top, req.box_width, req.box_height} <= pending_boxes[0];
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Receiver stall pattern plus one long hold-off.
   int hold_count = 0;
   int stall_phase = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (long_hold) begin
         hold_count <= hold_count + 1;
         rsp.ready <= (hold_count >= 200);
      end else begin
         stall_phase <= stall_phase + 1;
         if (stall_phase[8]) rsp.ready <= 1'b1;
         else rsp.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Monitor.
   always @(posedge clock) begin
      ground_type want, got;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.ground_x, rsp.ground_y, rsp.offset_x, rsp.offset_y,
                 rsp.in_region, rsp.degenerate};
         received++;
         if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item %p", got);
         end else begin
            want = expected_points.pop_front();
            if (got.degen) degen_seen++;
            if (got.in_reg) in_reg_seen++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic random_phase(int count, int mode);
      for (int i = 0; i < count; i++) add_box(random_box(mode));
   endtask

   initial begin
      for (int i = 0; i < bfg_pkg::NUM_REGS; i++) shadow_regs[i] = bfg_pkg::RESET_VALS[i];
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      add_box('{0, 0, 0, 0});
      add_box('{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF});
      add_box('{1, 0, 1, 1});
      add_box('{0, 1, 3, 3});
      add_box('{8, 4, 0, 0});
      add_box('{9, 4, 1, 0});
      add_box('{12'hAAA, 12'h555, 12'h555, 12'hAAA});
      add_box('{12'h555, 12'hAAA, 12'hAAA, 12'h555});
      drain_pipeline();

      // Zero denominator, saturating quotients and offsets, inverted region.
      write_reg(bfg_pkg::REG_COEF3, q24_pair(0, 0));
      write_reg(bfg_pkg::REG_COEF4, 64'hFFFF_FFFF_0000_0000);
      write_reg(bfg_pkg::REG_CAMERA, q24_pair(32'h7FFF_FFFF, 32'h8000_0000));
      write_reg(bfg_pkg::REG_RMIN, q24_pair(5, 5));
      write_reg(bfg_pkg::REG_RMAX, q24_pair(-5, -5));
      add_box('{3, 3, 3, 3});
      add_box('{0, 0, 0, 0});
      drain_pipeline();
      write_reg(bfg_pkg::REG_COEF0, q24_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF));
      write_reg(bfg_pkg::REG_COEF1, q24_pair(32'h8000_0000, 32'h8000_0000));
      write_reg(bfg_pkg::REG_COEF2, q24_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF));
      write_reg(bfg_pkg::REG_COEF4, q24_pair(1, 0));
      write_reg(bfg_pkg::REG_CAMERA, q24_pair(32'h8000_0000, 32'h7FFF_FFFF));
      write_reg(bfg_pkg::REG_RMIN, q24_pair(32'h8000_0000, 32'h8000_0000));
      write_reg(bfg_pkg::REG_RMAX, q24_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF));
      add_box('{0, 0, 0, 0});
      add_box('{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF});
      add_box('{5, 7, 2, 9});
      drain_pipeline();
      write_reg(bfg_pkg::REG_COEF4, q24_pair(-1, 0));
      add_box('{5, 7, 2, 9});
      add_box('{12'hFFF, 0, 12'hFFF, 0});
      drain_pipeline();

      // Long receiver hold-off so the pipeline fills and stalls its input.
      long_hold = 1'b1;
      random_phase(150, 0);
      drain_pipeline();
      long_hold = 1'b0;

      for (int phase = 0; phase < 6; phase++) begin
         for (int r = 0; r < bfg_pkg::NUM_REGS; r++) begin
            logic [63:0] v;
            case ($urandom_range(0, 3))
               0: v = {$urandom, $urandom};
               1: v = q24_pair($urandom_range(0, 1 << 25) - (1 << 24),
                               $urandom_range(0, 1 << 25) - (1 << 24));
               2: v = q24_pair($urandom_range(0, 1 << 15) - (1 << 14),
                               $urandom_range(0, 1 << 15) - (1 << 14));
               default: v = bfg_pkg::RESET_VALS[r];
            endcase
            if (r == bfg_pkg::REG_COEF3 && phase == 2) v = 64'd0;
            write_reg(r[bfg_pkg::IDX_BITS-1:0], v);
         end
         random_phase(200, phase % 2);
         wait (pending_boxes.size() <= 100);
         sender_paused = 1'b1;
         wait (expected_points.size() == 0);
         sender_paused = 1'b0;
         drain_pipeline();
      end

      for (int i = 0; i < bfg_pkg::NUM_REGS; i++) begin
         write_reg(i[bfg_pkg::IDX_BITS-1:0], bfg_pkg::RESET_VALS[i]);
      end
      random_phase(90, 0);
      drain_pipeline();

      $display("checked %0d result items across several register settings", received);
      $display("%0d degenerate and %0d in-region results seen", degen_seen, in_reg_seen);
      if (mismatches == 0 && expected_points.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
